// ===== rtl/mpp_pkg.sv =====
package mpp_pkg;

  // Fixed header layout and limits
  localparam int MAX_PARTS_LIMIT    = 16384;
  localparam int FIXED_HEADER_BYTES = 28;

  // Width of the header end (fixed bytes + 4 * count) for a 15-bit count
  localparam int CEND_W = 18;

  localparam logic [16:0]       PARTS_LIM = 17'(MAX_PARTS_LIMIT);
  localparam logic [31:0]       FHB_LEN   = 32'(FIXED_HEADER_BYTES);
  localparam logic [CEND_W-1:0] FHB_END   = CEND_W'(FIXED_HEADER_BYTES);

  // Register reset values
  localparam logic [31:0] SIG_RESET       = 32'h7861_6d6f;
  localparam logic [14:0] MAX_COUNT_RESET = 15'd16384;
  localparam logic [24:0] MAX_BYTES_RESET = 25'd16777216;

  // Register indexes
  localparam logic [1:0] CFG_SIGNATURE = 2'd0;
  localparam logic [1:0] CFG_MAX_COUNT = 2'd1;
  localparam logic [1:0] CFG_MAX_BYTES = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_PART   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_SIGNATURE = 3'd2;
  localparam logic [2:0] ST_COUNT     = 3'd3;
  localparam logic [2:0] ST_SIZE      = 3'd4;
  localparam logic [2:0] ST_OVERRUN   = 3'd5;

  typedef enum logic [2:0] {
    POS_SIG,
    POS_TYPE,
    POS_SES0,
    POS_SES1,
    POS_SES2,
    POS_SES3,
    POS_COUNT,
    POS_SIZES
  } pos_t;

  typedef struct packed {
    logic [31:0] header_word;
    logic        first_word;
    logic [31:0] packet_bytes;
  } item_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [13:0] part_index;
    logic [31:0] part_offset;
    logic [24:0] part_size;
    logic [14:0] parts_total;
    logic [2:0]  status_code;
    logic [63:0] session_high;
    logic [63:0] session_low;
    logic        packet_done;
  } result_t;

  // Word plus the checks that depend only on the word and the registers
  typedef struct packed {
    logic [31:0]       word;
    logic              first;
    logic [31:0]       pkt_bytes;
    logic              sig_ok;
    logic              cnt_bad;
    logic [14:0]       cnt_val;
    logic [CEND_W-1:0] cnt_end;
    logic              size_bad;
    logic [24:0]       size_val;
  } cls_t;

endpackage

// ===== rtl/multipart_packet_header_parser_top.sv =====
// Multipart packet header parser.
// item channel: one 32-bit header word per beat (item_valid / item_stall);
//   first_word marks word 0 of a packet and carries packet_bytes with it.
// result channel: part descriptors and one accept/reject summary per closed packet
//   (result_valid / result_stall); packet_done marks the summary.
// cfg channel: cfg_valid / cfg_ready with cfg_index and cfg_data; ready is
//   always high. Index 0 signature, 1 max part count, 2 max part bytes.
// Throughput: one word per cycle while item_stall is low. A word is registered
//   in the queue, its results in the result buffer. The last part-size word
//   gives descriptor then accept summary, leaving over two consecutive beats.
// Front classifies each word against the registers (signature, count and
//   size limits, header end); a 2-entry queue feeds the back, which holds the
//   packet state and writes results into a 4-entry result buffer. The back
//   takes a word only when the buffer has room for two results.
// Reset (sync, rst high): registers return to defaults, queues empty, and the
//   parser waits for a first word; other words are dropped silently.
// A stalled receiver fills the result buffer, then the queue, then raises
//   item_stall; nothing is lost.
module multipart_packet_header_parser_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  mpp_pkg::item_t          item,
  output logic                    result_valid,
  input  logic                    result_stall,
  output mpp_pkg::result_t        result,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [31:0]             cfg_data
);
  import mpp_pkg::*;

  localparam int CLS_W = $bits(cls_t);

  // config registers
  logic [31:0] signature;
  logic [14:0] max_count;
  logic [24:0] max_bytes;

  cls_t             cls_in;
  cls_t             cls_out;
  logic [CLS_W-1:0] q_rd;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic             q_push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      signature <= SIG_RESET;
      max_count <= MAX_COUNT_RESET;
      max_bytes <= MAX_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SIGNATURE: signature <= cfg_data;
        CFG_MAX_COUNT: max_count <= cfg_data[14:0];
        CFG_MAX_BYTES: max_bytes <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  // front: per-word checks
  mpp_front u_front (
    .item      (item),
    .signature (signature),
    .max_count (max_count),
    .max_bytes (max_bytes),
    .cls       (cls_in)
  );

  assign item_stall = q_full;
  assign q_push     = item_valid && !q_full;

  // decoupling queue between front and back
  mpp_fifo #(
    .W     (CLS_W),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (cls_in),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_rd)
  );

  assign cls_out = cls_t'(q_rd);

  // back: packet state and result generation
  mpp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (cls_out),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== rtl/mpp_front.sv =====
module mpp_front (
  input  mpp_pkg::item_t       item,
  input  logic [31:0]          signature,
  input  logic [14:0]          max_count,
  input  logic [24:0]          max_bytes,
  output mpp_pkg::cls_t        cls
);
  import mpp_pkg::*;

  logic [16:0] limit;

  always_comb begin
    // effective count limit: smaller of register and build limit
    limit = ({2'b00, max_count} > PARTS_LIM) ? PARTS_LIM : {2'b00, max_count};

    cls.word      = item.header_word;
    cls.first     = item.first_word;
    cls.pkt_bytes = item.packet_bytes;
    cls.sig_ok    = (item.header_word == signature);
    cls.cnt_bad   = (item.header_word > {15'd0, limit});
    cls.cnt_val   = item.header_word[14:0];
    cls.cnt_end   = FHB_END + {1'b0, item.header_word[14:0], 2'b00};
    cls.size_bad  = (item.header_word > {7'd0, max_bytes});
    cls.size_val  = item.header_word[24:0];
  end

endmodule

// ===== rtl/mpp_fifo.sv =====
module mpp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         pop_valid,
  input  logic         pop,
  output logic [W-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [CW-1:0] count;

  assign full      = (count == FULL_CNT);
  assign pop_valid = (count != '0);
  assign pop_data  = mem[head];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == LAST) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == LAST) ? '0 : head + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

// ===== rtl/mpp_back.sv =====
module mpp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  mpp_pkg::cls_t     q_data,
  output logic              q_pop,
  output logic              result_valid,
  input  logic              result_stall,
  output mpp_pkg::result_t  result
);
  import mpp_pkg::*;

  // packet state
  pos_t        pos;
  pos_t        pos_next;
  logic        closed;
  logic        closed_next;
  logic [31:0] length_held;
  logic [31:0] length_next;
  logic [14:0] count_held;
  logic [14:0] count_next;
  logic [14:0] parts_seen;
  logic [14:0] seen_next;
  logic [31:0] running_end;
  logic [31:0] end_next;
  logic [63:0] ses_hi;
  logic [63:0] ses_hi_next;
  logic [63:0] ses_lo;
  logic [63:0] ses_lo_next;

  logic        live;
  logic        do_sum;
  logic        do_desc;
  logic [1:0]  sum_kind;
  logic [2:0]  sum_status;
  logic [32:0] part_end;
  result_t     desc;
  result_t     summ;
  result_t     res0;
  result_t     res1;
  logic [1:0]  push_n;

  // result buffer: up to two results per word
  result_t     obuf [4];
  logic [1:0]  ob_head;
  logic [1:0]  ob_tail;
  logic [2:0]  ob_count;
  logic        ob_pop;

  assign q_pop        = q_valid && (ob_count <= 3'd2);
  assign result_valid = (ob_count != 3'd0);
  assign result       = obuf[ob_head];
  assign ob_pop       = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= POS_SIG;
      closed      <= 1'b1;
      length_held <= '0;
      count_held  <= '0;
      parts_seen  <= '0;
      running_end <= '0;
      ses_hi      <= '0;
      ses_lo      <= '0;
    end else if (q_pop) begin
      pos         <= pos_next;
      closed      <= closed_next;
      length_held <= length_next;
      count_held  <= count_next;
      parts_seen  <= seen_next;
      running_end <= end_next;
      ses_hi      <= ses_hi_next;
      ses_lo      <= ses_lo_next;
    end
  end

  always_comb begin
    // a first word restarts the packet state
    length_next = q_data.first ? q_data.pkt_bytes : length_held;
    pos_next    = q_data.first ? POS_SIG : pos;
    closed_next = q_data.first ? 1'b0 : closed;
    count_next  = q_data.first ? '0 : count_held;
    seen_next   = q_data.first ? '0 : parts_seen;
    end_next    = q_data.first ? '0 : running_end;
    ses_hi_next = q_data.first ? '0 : ses_hi;
    ses_lo_next = q_data.first ? '0 : ses_lo;
    live        = q_data.first || !closed;
    do_sum      = 1'b0;
    do_desc     = 1'b0;
    sum_kind    = KIND_REJECT;
    sum_status  = ST_OK;
    part_end    = {1'b0, end_next} + {8'd0, q_data.size_val};
    desc        = '0;

    if (live) begin
      case (pos_next)
        POS_SIG: begin
          if (length_next < FHB_LEN) begin
            do_sum     = 1'b1;
            sum_status = ST_SHORT;
          end else if (!q_data.sig_ok) begin
            do_sum     = 1'b1;
            sum_status = ST_SIGNATURE;
          end else begin
            pos_next = POS_TYPE;
          end
        end
        POS_TYPE: pos_next = POS_SES0;
        POS_SES0: begin
          ses_lo_next[31:0] = q_data.word;
          pos_next = POS_SES1;
        end
        POS_SES1: begin
          ses_lo_next[63:32] = q_data.word;
          pos_next = POS_SES2;
        end
        POS_SES2: begin
          ses_hi_next[31:0] = q_data.word;
          pos_next = POS_SES3;
        end
        POS_SES3: begin
          ses_hi_next[63:32] = q_data.word;
          pos_next = POS_COUNT;
        end
        POS_COUNT: begin
          if (q_data.cnt_bad) begin
            do_sum     = 1'b1;
            sum_status = ST_COUNT;
          end else begin
            count_next = q_data.cnt_val;
            end_next   = {{(32 - CEND_W){1'b0}}, q_data.cnt_end};
            pos_next   = POS_SIZES;
            if (end_next > length_next) begin
              do_sum     = 1'b1;
              sum_status = ST_OVERRUN;
            end else if (q_data.cnt_val == '0) begin
              do_sum   = 1'b1;
              sum_kind = KIND_ACCEPT;
            end
          end
        end
        POS_SIZES: begin
          if (q_data.size_bad) begin
            do_sum     = 1'b1;
            sum_status = ST_SIZE;
          end else if (part_end > {1'b0, length_next}) begin
            do_sum     = 1'b1;
            sum_status = ST_OVERRUN;
          end else begin
            do_desc          = 1'b1;
            desc.item_kind   = KIND_PART;
            desc.part_index  = seen_next[13:0];
            desc.part_offset = end_next;
            desc.part_size   = q_data.size_val;
            end_next         = part_end[31:0];
            seen_next        = seen_next + 15'd1;
            if (seen_next >= count_next) begin
              do_sum   = 1'b1;
              sum_kind = KIND_ACCEPT;
            end
          end
        end
        default: pos_next = POS_SIG;
      endcase
    end

    if (do_sum) begin
      closed_next = 1'b1;
    end

    summ              = '0;
    summ.item_kind    = sum_kind;
    summ.part_index   = seen_next[13:0];
    summ.parts_total  = count_next;
    summ.status_code  = sum_status;
    summ.session_high = ses_hi_next;
    summ.session_low  = ses_lo_next;
    summ.packet_done  = 1'b1;

    if (do_desc) begin
      res0   = desc;
      res1   = summ;
      push_n = do_sum ? 2'd2 : 2'd1;
    end else begin
      res0   = summ;
      res1   = summ;
      push_n = do_sum ? 2'd1 : 2'd0;
    end
    if (!q_pop) begin
      push_n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      obuf[ob_tail] <= res0;
    end
    if (push_n == 2'd2) begin
      obuf[ob_tail + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_head  <= '0;
      ob_tail  <= '0;
      ob_count <= '0;
    end else begin
      ob_tail  <= ob_tail + push_n;
      ob_head  <= ob_head + 2'(ob_pop);
      ob_count <= ob_count + {1'b0, push_n} - 3'(ob_pop);
    end
  end

`ifndef SYNTHESIS
  a_ob_bound: assert property (@(posedge clk) disable iff (rst)
    ob_count <= 3'd4)
    else $error("result buffer overflow");

  a_closed_silent: assert property (@(posedge clk) disable iff (rst)
    (q_pop && closed && !q_data.first) |-> (push_n == 2'd0))
    else $error("result from a word after packet close");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (push_n == 2'd2) |-> (res0.item_kind == KIND_PART && res1.item_kind == KIND_ACCEPT))
    else $error("two results that are not descriptor then accept");

  a_close_after_sum: assert property (@(posedge clk) disable iff (rst)
    (q_pop && do_sum) |=> closed)
    else $error("packet left open after summary");
`endif

endmodule

// ===== verif/multipart_packet_header_parser_top_tb.sv =====
`timescale 1ns / 100ps

// Parser under test: header words in, part descriptors and one summary per
// packet out. Every beat accepted on the item channel goes through a parser
// model in this file, which queues the results it owes; every result beat is
// checked field by field against the oldest entry of that queue.
module multipart_packet_header_parser_top_tb;
  import mpp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;  // far above the slowest clean run
  localparam int DRAIN_CYCLES = 12;     // front queue is 2 deep

  // Ways a random packet can be spoiled on purpose
  typedef enum int {
    CLEAN,
    SHORT_LEN,
    BAD_SIG,
    BAD_COUNT,
    HEADER_OVERRUN,
    BIG_PART,
    PART_OVERRUN,
    CUT_SHORT
  } flaw_t;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  item_t       item;
  logic        result_valid;
  logic        result_stall;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  multipart_packet_header_parser_top uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Register shadows, at their reset values
  logic [31:0] sig_reg         = SIG_RESET;
  logic [14:0] cnt_limit_reg   = MAX_COUNT_RESET;
  logic [24:0] bytes_limit_reg = MAX_BYTES_RESET;

  // Parser model state, at its reset values (closed: waiting for a first word)
  pos_t        word_pos      = POS_SIG;
  logic [31:0] len_held      = '0;
  logic [14:0] count_held    = '0;
  logic [14:0] parts_done    = '0;
  logic [63:0] run_end       = '0;
  logic [63:0] ses_low       = '0;
  logic [63:0] ses_high      = '0;
  logic        packet_closed = 1'b1;

  result_t results_due[$];  // results owed by the parser, oldest first
  item_t   pkt_words[$];    // words of the packet being built
  int      words_sent = 0;
  int      fail_count = 0;
  int      cycle_count;
  logic    send_gaps = 1'b1;  // sender idles between beats
  logic    sink_gaps = 1'b1;  // receiver stalls between beats
  result_t want_r;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------

  // Summary beat: closes the packet, carries count and session seen so far
  function automatic void close_packet(input logic [1:0] kind, input logic [2:0] status);
    result_t s;
    s = '0;
    s.item_kind    = kind;
    s.part_index   = parts_done[13:0];
    s.parts_total  = count_held;
    s.status_code  = status;
    s.session_high = ses_high;
    s.session_low  = ses_low;
    s.packet_done  = 1'b1;
    results_due.push_back(s);
    packet_closed = 1'b1;
  endfunction

  function automatic void parse_word(input item_t it);
    logic [31:0] w;
    logic [31:0] lim;
    result_t     d;
    w = it.header_word;
    if (it.first_word) begin
      // first word always restarts, abandoning any open packet silently
      word_pos      = POS_SIG;
      len_held      = it.packet_bytes;
      count_held    = '0;
      parts_done    = '0;
      run_end       = '0;
      ses_low       = '0;
      ses_high      = '0;
      packet_closed = 1'b0;
    end else if (packet_closed) begin
      return;
    end
    case (word_pos)
      POS_SIG: begin
        // length check wins over the signature check
        if (len_held < FHB_LEN) close_packet(KIND_REJECT, ST_SHORT);
        else if (w != sig_reg) close_packet(KIND_REJECT, ST_SIGNATURE);
        else word_pos = POS_TYPE;
      end
      POS_TYPE: word_pos = POS_SES0;
      POS_SES0: begin
        ses_low[31:0] = w;
        word_pos = POS_SES1;
      end
      POS_SES1: begin
        ses_low[63:32] = w;
        word_pos = POS_SES2;
      end
      POS_SES2: begin
        ses_high[31:0] = w;
        word_pos = POS_SES3;
      end
      POS_SES3: begin
        ses_high[63:32] = w;
        word_pos = POS_COUNT;
      end
      POS_COUNT: begin
        // count register above the hard limit is clamped to it
        lim = ({17'b0, cnt_limit_reg} > 32'(MAX_PARTS_LIMIT)) ?
              32'(MAX_PARTS_LIMIT) : {17'b0, cnt_limit_reg};
        if (w > lim) begin
          close_packet(KIND_REJECT, ST_COUNT);
        end else begin
          count_held = w[14:0];
          run_end = 64'(FIXED_HEADER_BYTES) + 64'(w) * 4;
          if (run_end > {32'b0, len_held}) begin
            close_packet(KIND_REJECT, ST_OVERRUN);
          end else begin
            word_pos = POS_SIZES;
            if (w == 0) close_packet(KIND_ACCEPT, ST_OK);
          end
        end
      end
      default: begin
        if (w > {7'b0, bytes_limit_reg}) begin
          close_packet(KIND_REJECT, ST_SIZE);
        end else if (run_end + 64'(w) > {32'b0, len_held}) begin
          close_packet(KIND_REJECT, ST_OVERRUN);
        end else begin
          d = '0;
          d.item_kind   = KIND_PART;
          d.part_index  = parts_done[13:0];
          d.part_offset = run_end[31:0];
          d.part_size   = w[24:0];
          results_due.push_back(d);
          run_end = run_end + 64'(w);
          parts_done++;
          // last part: descriptor and accept summary from the same word
          if (parts_done >= count_held) close_packet(KIND_ACCEPT, ST_OK);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random stall per beat, checker on every accepted beat
  // ---------------------------------------------------------------------

  initial begin : result_sink
    int hold;
    result_stall <= 1'b0;
    forever begin
      hold = sink_gaps ? $urandom_range(0, 16) : 0;
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        result_stall <= 1'b0;
      end
      do @(posedge clk); while (!result_valid);
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // All TB drives are nonblocking, so values read here are the pre-edge ones
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (results_due.size() == 0) begin
        fail_count++;
        $display("%0t: result beat with nothing expected: expected none, actual %h",
                 $time, result);
      end else begin
        want_r = results_due.pop_front();
        check_field("item_kind",    want_r.item_kind,    result.item_kind);
        check_field("part_index",   want_r.part_index,   result.part_index);
        check_field("part_offset",  want_r.part_offset,  result.part_offset);
        check_field("part_size",    want_r.part_size,    result.part_size);
        check_field("parts_total",  want_r.parts_total,  result.parts_total);
        check_field("status_code",  want_r.status_code,  result.status_code);
        check_field("session_high", want_r.session_high, result.session_high);
        check_field("session_low",  want_r.session_low,  result.session_low);
        check_field("packet_done",  want_r.packet_done,  result.packet_done);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("multipart_packet_header_parser_top_tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Item side
  // ---------------------------------------------------------------------

  // One beat: random idle, then hold valid and payload until taken.
  // Valid stays high on return so a back-to-back beat needs no re-raise.
  task automatic send_word(input item_t it);
    int gap;
    gap = send_gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    words_sent++;
    parse_word(it);
  endtask

  function automatic void add_word(input logic [31:0] w);
    item_t it;
    it.header_word  = w;
    it.first_word   = 1'b0;
    it.packet_bytes = $urandom;  // ignored off the first word
    pkt_words.push_back(it);
  endfunction

  // Signature word with length, then type word and four session words
  function automatic void begin_packet(input logic [31:0] len, input logic [31:0] sig);
    item_t it;
    pkt_words.delete();
    it.header_word  = sig;
    it.first_word   = 1'b1;
    it.packet_bytes = len;
    pkt_words.push_back(it);
    repeat (5) add_word($urandom);
  endfunction

  task automatic send_packet(input int n);
    for (int i = 0; i < n && i < pkt_words.size(); i++) send_word(pkt_words[i]);
  endtask

  task automatic send_loose_words(input int n);
    item_t it;
    repeat (n) begin
      it.header_word  = $urandom;
      it.first_word   = 1'b0;
      it.packet_bytes = $urandom;
      send_word(it);
    end
  endtask

  // Quiet point: all owed results out, then DRAIN_CYCLES more for words that
  // produce nothing but may still sit in the front queue
  task automatic wait_for_drain();
    item_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers back to back while the parser is quiet
  task automatic load_registers(input logic [31:0] sig, input logic [14:0] cnt,
                                input logic [24:0] bytes);
    logic [1:0]  idx [3];
    logic [31:0] vals [3];
    idx[0] = CFG_SIGNATURE;
    idx[1] = CFG_MAX_COUNT;
    idx[2] = CFG_MAX_BYTES;
    vals[0] = sig;
    vals[1] = {17'b0, cnt};
    vals[2] = {7'b0, bytes};
    wait_for_drain();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    sig_reg         = sig;
    cnt_limit_reg   = cnt;
    bytes_limit_reg = bytes;
  endtask

  // ---------------------------------------------------------------------
  // Directed tests (default registers unless noted)
  // ---------------------------------------------------------------------

  // Nothing open after reset: loose words must vanish
  task automatic test_idle_after_reset();
    send_loose_words(3);
  endtask

  task automatic test_word0_checks();
    begin_packet(32'd0, ~SIG_RESET);  // short beats bad signature
    send_packet(1);
    begin_packet(32'd27, SIG_RESET);
    send_packet(1);
    begin_packet(32'd28, SIG_RESET ^ 32'h8000_0000);
    send_packet(1);
    begin_packet(32'd28, SIG_RESET);  // minimum length, zero parts
    add_word(32'd0);
    send_packet(pkt_words.size());
    begin_packet(32'hFFFF_FFFF, SIG_RESET);  // left open, next test abandons it
    send_packet(3);
  endtask

  task automatic test_count_word();
    begin_packet(32'hFFFF_FFFF, SIG_RESET);
    add_word(32'd16385);
    send_packet(pkt_words.size());
    begin_packet(32'hFFFF_FFFF, SIG_RESET);
    add_word(32'hFFFF_FFFF);
    send_packet(pkt_words.size());
    begin_packet(32'd39, SIG_RESET);  // size words would run one byte past
    add_word(32'd3);
    send_packet(pkt_words.size());
    begin_packet(32'd28 + 32'd4 * 32'd16384 + 32'd100, SIG_RESET);  // count at limit
    add_word(32'd16384);
    add_word(32'd0);
    add_word(32'd5);
    send_packet(pkt_words.size());
  endtask

  task automatic test_part_sizes();
    // largest part, empty part, part ending exactly at the length
    begin_packet(32'd40 + 32'(MAX_BYTES_RESET) + 32'd7, SIG_RESET);
    add_word(32'd3);
    add_word(32'(MAX_BYTES_RESET));
    add_word(32'd0);
    add_word(32'd7);
    send_packet(pkt_words.size());
    begin_packet(32'hFFFF_FFFF, SIG_RESET);
    add_word(32'd2);
    add_word(32'(MAX_BYTES_RESET) + 32'd1);
    send_packet(pkt_words.size());
    begin_packet(32'hFFFF_FFFF, SIG_RESET);  // negative if read as signed
    add_word(32'd2);
    add_word(32'd3);
    add_word(32'hFFFF_FFFF);
    send_packet(pkt_words.size());
    begin_packet(32'd66, SIG_RESET);  // second part one byte too long
    add_word(32'd2);
    add_word(32'd10);
    add_word(32'd21);
    send_packet(pkt_words.size());
    begin_packet(32'd32, SIG_RESET);
    add_word(32'd1);
    add_word(32'd0);
    send_packet(pkt_words.size());
  endtask

  task automatic test_restart();
    begin_packet(32'd200, SIG_RESET);
    send_packet(4);  // dropped inside the session id
    begin_packet(32'd200, SIG_RESET);
    add_word(32'd1);
    add_word(32'd50);
    send_packet(pkt_words.size());
    send_loose_words(2);
  endtask

  task automatic test_register_extremes();
    load_registers(32'd0, 15'd0, 25'd0);
    begin_packet(32'd28, 32'd0);
    add_word(32'd0);
    send_packet(pkt_words.size());
    begin_packet(32'd100, 32'd0);
    add_word(32'd1);
    send_packet(pkt_words.size());
    begin_packet(32'd28, SIG_RESET);
    send_packet(1);
    // count register above the hard limit: clamp applies
    load_registers(32'hFFFF_FFFF, 15'h7FFF, MAX_BYTES_RESET);
    begin_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_word(32'd16385);
    send_packet(pkt_words.size());
    begin_packet(32'd32 + 32'(MAX_BYTES_RESET), 32'hFFFF_FFFF);
    add_word(32'd1);
    add_word(32'(MAX_BYTES_RESET));
    send_packet(pkt_words.size());
  endtask

  // ---------------------------------------------------------------------
  // Random packets: mostly well formed, some spoiled in one place
  // ---------------------------------------------------------------------

  task automatic random_packet();
    int unsigned lim, count, pick, n;
    flaw_t       flaw;
    logic [31:0] sig, count_word, len, sz;
    logic [31:0] sizes[$];
    logic [63:0] hdr_end, total;
    lim = ({17'b0, cnt_limit_reg} > 32'(MAX_PARTS_LIMIT)) ?
          MAX_PARTS_LIMIT : cnt_limit_reg;
    count = $urandom_range(0, lim < 6 ? lim : 6);
    if ($urandom_range(0, 15) == 0 && lim > 6) count = $urandom_range(7, lim < 24 ? lim : 24);
    hdr_end = 64'(FIXED_HEADER_BYTES) + 64'(count) * 4;
    total = hdr_end;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) sz = '0;
      else if (pick == 1) sz = {7'b0, bytes_limit_reg};
      else sz = $urandom_range(0, bytes_limit_reg < 400 ? bytes_limit_reg : 400);
      sizes.push_back(sz);
      total = total + 64'(sz);
    end
    // exact fit, a little slack, or anything up to the full 32-bit length
    len = total[31:0];
    case ($urandom_range(0, 3))
      1: len = total[31:0] + $urandom_range(1, 64);
      2: len = $urandom_range(total[31:0], 32'hFFFF_FFFF);
      default: ;
    endcase
    sig = sig_reg;
    count_word = count;
    n = 7 + count;
    pick = $urandom_range(0, 13);
    flaw = (pick > CUT_SHORT) ? CLEAN : flaw_t'(pick);
    case (flaw)
      SHORT_LEN: len = $urandom_range(0, FIXED_HEADER_BYTES - 1);
      BAD_SIG: sig = sig_reg ^ (32'h1 << $urandom_range(0, 31));
      BAD_COUNT: count_word = $urandom_range(0, 1) ? lim + 1 :
                              $urandom_range(lim + 1, 32'hFFFF_FFFF);
      HEADER_OVERRUN:
        if (count > 0) len = $urandom_range(FIXED_HEADER_BYTES, hdr_end[31:0] - 1);
      BIG_PART:
        if (count > 0)
          sizes[$urandom_range(0, count - 1)] =
            $urandom_range(32'(bytes_limit_reg) + 1, 32'hFFFF_FFFF);
      PART_OVERRUN:
        if (total > hdr_end) len = $urandom_range(hdr_end[31:0], total[31:0] - 1);
      CUT_SHORT: n = $urandom_range(1, 6 + count);  // next first word abandons it
      default: ;
    endcase
    begin_packet(len, sig);
    add_word(count_word);
    foreach (sizes[i]) add_word(sizes[i]);
    send_gaps = ($urandom_range(0, 3) != 0);
    sink_gaps = ($urandom_range(0, 3) != 0);
    send_packet(n);
    if ($urandom_range(0, 3) == 0) send_loose_words($urandom_range(1, 3));
  endtask

  task automatic run_random_phase(input int n_words);
    int target;
    target = words_sent + n_words;
    while (words_sent < target) random_packet();
  endtask

  task automatic test_random_traffic();
    load_registers(SIG_RESET, MAX_COUNT_RESET, MAX_BYTES_RESET);
    run_random_phase(110);
    load_registers($urandom, 15'd3, 25'd300);
    run_random_phase(100);
    load_registers(32'hFFFF_FFFF, 15'h7FFF, 25'd0);  // only empty parts pass
    run_random_phase(90);
    load_registers($urandom, 15'($urandom_range(1, MAX_PARTS_LIMIT)),
                   25'($urandom_range(1, MAX_BYTES_RESET)));
    run_random_phase(110);
  endtask

  initial begin
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_SIGNATURE;
    cfg_data   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_after_reset();
    test_word0_checks();
    test_count_word();
    test_part_sizes();
    test_restart();
    test_register_extremes();
    test_random_traffic();

    wait_for_drain();
    if (fail_count == 0) begin
      $display("multipart_packet_header_parser_top_tb: clean");
    end else begin
      $display("multipart_packet_header_parser_top_tb: errors");
    end
    $finish;
  end

endmodule
